FILE: rtl/core/grt_pkg.sv
// grt_pkg: shared widths, constants and helper functions for the grid ray walk
// no dependencies; imported by grt_mul, grt_div and grid_ray_traversal
package grt_pkg;
  localparam int FRAC_BITS = 12;
  localparam int MAP_W_DEF = 8;
  localparam int MAP_H_DEF = 8;
  localparam int MAP_BITS  = 64;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int SXW       = 15;
  localparam int EXW       = 23;
  localparam int HW        = 16;
  localparam int UW        = 12;
  localparam int CW        = 26;
  localparam int MW        = CW - 1;
  localparam int AW        = FRAC_BITS + 1;
  localparam int PW        = AW + MW;
  localparam int IW        = CW - FRAC_BITS;

  function automatic logic [MW-1:0] mag(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] a;
    a = v[CW-1] ? -v : v;
    return a[MW-1:0];
  endfunction

  function automatic logic [UW-1:0] to_q012(input logic [FRAC_BITS-1:0] f);
    logic [FRAC_BITS+UW-1:0] w;
    w = (FRAC_BITS + UW)'(f) << UW;
    return w[FRAC_BITS+UW-1 -: UW];
  endfunction
endpackage

FILE: rtl/core/grt_mul.sv
// grt_mul: shift-add multiplier, one bit of a per cycle
// depends on grt_pkg
module grt_mul (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [grt_pkg::AW-1:0] a,
  input  logic [grt_pkg::MW-1:0] b,
  output logic [grt_pkg::PW-1:0] prod,
  output logic                   done
);
  import grt_pkg::*;

  localparam int CNW = $clog2(AW);

  logic [AW-1:0]  a_sh;
  logic [PW-1:0]  b_sh;
  logic [CNW-1:0] cnt;
  logic           busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && cnt == CNW'(AW - 1);
      if (start) begin
        prod <= '0;
        a_sh <= a;
        b_sh <= PW'(b);
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (a_sh[0]) prod <= prod + b_sh;
        a_sh <= a_sh >> 1;
        b_sh <= b_sh << 1;
        if (cnt == CNW'(AW - 1)) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + CNW'(1);
        end
      end
    end
  end
endmodule

FILE: rtl/core/grt_div.sv
// grt_div: restoring divider, one quotient bit per cycle
// depends on grt_pkg; quotient must fit in AW bits
module grt_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [grt_pkg::PW-1:0] dividend,
  input  logic [grt_pkg::MW-1:0] divisor,
  output logic [grt_pkg::AW-1:0] quot,
  output logic                   done
);
  import grt_pkg::*;

  localparam int CNW = $clog2(AW);

  logic [PW-1:0]  rem;
  logic [PW-1:0]  dsh;
  logic [PW:0]    diff;
  logic [CNW-1:0] cnt;
  logic           busy;

  assign diff = {1'b0, rem} - {1'b0, dsh};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && cnt == CNW'(AW - 1);
      if (start) begin
        rem  <= dividend;
        dsh  <= PW'(divisor) << (AW - 1);
        quot <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!diff[PW]) rem <= diff[PW-1:0];
        quot <= {quot[AW-2:0], !diff[PW]};
        dsh  <= dsh >> 1;
        if (cnt == CNW'(AW - 1)) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + CNW'(1);
        end
      end
    end
  end
endmodule

FILE: rtl/core/grid_ray_traversal.sv
// grid_ray_traversal: one ray per beat walked cell by cell over the occupancy map
// each cell step: setup, serial multiply of FRAC_BITS+1 bits, compare,
// serial divide of FRAC_BITS+1 bits, update; multiply and divide start strobes are registered
// at most 2*(MAP_W+MAP_H)+4 steps; one ray at a time, next ray taken while result waits
// reset: control state cleared, map register reads all zero
module grid_ray_traversal #(
  parameter int MAP_W = grt_pkg::MAP_W_DEF,
  parameter int MAP_H = grt_pkg::MAP_H_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [grt_pkg::MAP_BITS-1:0] map_cells,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [grt_pkg::SXW-1:0] start_x,
  input  logic [grt_pkg::SXW-1:0] start_y,
  input  logic signed [grt_pkg::EXW-1:0] end_x,
  input  logic signed [grt_pkg::EXW-1:0] end_y,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    hit,
  output logic [grt_pkg::HW-1:0]  hit_x,
  output logic [grt_pkg::HW-1:0]  hit_y,
  output logic [grt_pkg::UW-1:0]  wall_u
);
  import grt_pkg::*;

  localparam int MAXS = 2 * (MAP_W + MAP_H) + 4;
  localparam int SNW  = $clog2(MAXS + 1);
  localparam int MIW  = $clog2(MAP_W * MAP_H);
  localparam logic signed [IW-1:0] MAPW_S = IW'(MAP_W);
  localparam logic signed [IW-1:0] MAPH_S = IW'(MAP_H);
  localparam logic signed [CW-1:0] XMAX = CW'(MAP_W * ONE);
  localparam logic signed [CW-1:0] YMAX = CW'(MAP_H * ONE);

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_MUL, S_CMP, S_DIV, S_UPD, S_DONE
  } state_t;

  state_t state;
  logic [MAP_BITS-1:0] map_reg;

  logic signed [CW-1:0] x, y, x1, y1, wallx, wally;
  logic signed [IW-1:0] ix, iy, ex, ey;
  logic [SNW-1:0] n;
  logic [AW-1:0] ax, ay;
  logic [MW-1:0] adx, ady;
  logic dx_zero, dy_zero, dx_neg, dy_neg, stepx;
  logic res_hit;
  logic [HW-1:0] res_x, res_y;
  logic [UW-1:0] res_u;

  logic mul_start, div_start, mdone_x, mdone_y, div_done;
  logic [PW-1:0] pxy, pyx, dividend;
  logic [MW-1:0] divisor;
  logic [AW-1:0] quot;

  // input cell setup
  logic signed [CW-1:0] sx, sy, ex_c, ey_c;
  logic signed [IW-1:0] ix0, iy0;
  assign sx   = $signed(CW'(start_x));
  assign sy   = $signed(CW'(start_y));
  assign ex_c = CW'(end_x);
  assign ey_c = CW'(end_y);
  assign ix0  = $signed(sx[CW-1:FRAC_BITS])
              - ((sx[FRAC_BITS-1:0] == '0 && ex_c < sx) ? IW'(1) : IW'(0));
  assign iy0  = $signed(sy[CW-1:FRAC_BITS])
              - ((sy[FRAC_BITS-1:0] == '0 && ey_c < sy) ? IW'(1) : IW'(0));

  // step setup
  logic signed [CW-1:0] dx, dy, wx_c, wy_c;
  logic signed [IW-1:0] fx, fy;
  assign dx = x1 - x;
  assign dy = y1 - y;
  assign fx = $signed(x[CW-1:FRAC_BITS]);
  assign fy = $signed(y[CW-1:FRAC_BITS]);

  always_comb begin
    wx_c = x;
    if (dx > 0) wx_c = {fx + IW'(1), {FRAC_BITS{1'b0}}};
    else if (dx < 0)
      wx_c = (x[FRAC_BITS-1:0] == '0) ? {fx - IW'(1), {FRAC_BITS{1'b0}}}
                                     : {fx, {FRAC_BITS{1'b0}}};
    wy_c = y;
    if (dy > 0) wy_c = {fy + IW'(1), {FRAC_BITS{1'b0}}};
    else if (dy < 0)
      wy_c = (y[FRAC_BITS-1:0] == '0) ? {fy - IW'(1), {FRAC_BITS{1'b0}}}
                                     : {fy, {FRAC_BITS{1'b0}}};
  end

  // update after divide
  logic signed [CW-1:0] qv, nx, ny;
  logic signed [IW-1:0] nix, niy;
  logic off_map, is_wall, at_end;
  logic [MIW-1:0] cidx;
  logic [HW-1:0] cx, cy;
  logic [UW-1:0] cu;

  assign qv = $signed(CW'(quot));

  always_comb begin
    if (stepx) begin
      nx  = wallx;
      ny  = dy_neg ? y - qv : y + qv;
      nix = dx_neg ? ix - IW'(1) : ix + IW'(1);
      niy = $signed(ny[CW-1:FRAC_BITS]);
      cu  = to_q012(ny[FRAC_BITS-1:0]);
    end else begin
      ny  = wally;
      nx  = dx_neg ? x - qv : x + qv;
      niy = dy_neg ? iy - IW'(1) : iy + IW'(1);
      nix = $signed(nx[CW-1:FRAC_BITS]);
      cu  = to_q012(nx[FRAC_BITS-1:0]);
    end
    off_map = nix < 0 || niy < 0 || nix >= MAPW_S || niy >= MAPH_S;
    cidx    = MIW'(int'(niy) * MAP_W + int'(nix));
    is_wall = off_map || map_reg[cidx];
    at_end  = nix == ex && niy == ey;
    if (nx < 0) cx = '0;
    else if (nx > XMAX) cx = XMAX[HW-1:0];
    else cx = nx[HW-1:0];
    if (ny < 0) cy = '0;
    else if (ny > YMAX) cy = YMAX[HW-1:0];
    else cy = ny[HW-1:0];
  end

  grt_mul u_mul_x (
    .clk(clk), .rst(rst), .start(mul_start), .a(ax), .b(ady),
    .prod(pxy), .done(mdone_x)
  );

  grt_mul u_mul_y (
    .clk(clk), .rst(rst), .start(mul_start), .a(ay), .b(adx),
    .prod(pyx), .done(mdone_y)
  );

  grt_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dividend),
    .divisor(divisor), .quot(quot), .done(div_done)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_reg <= '0;
    end else if (cfg_valid) begin
      map_reg <= map_cells;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      mul_start <= state == S_SETUP && !(dx == 0 && dy == 0);
      div_start <= state == S_CMP;
      out_valid <= state == S_DONE || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            x     <= sx;
            y     <= sy;
            x1    <= ex_c;
            y1    <= ey_c;
            ix    <= ix0;
            iy    <= iy0;
            ex    <= $signed(ex_c[CW-1:FRAC_BITS]);
            ey    <= $signed(ey_c[CW-1:FRAC_BITS]);
            n     <= '0;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (dx == 0 && dy == 0) begin
            res_hit <= 1'b0;
            res_x   <= '0;
            res_y   <= '0;
            res_u   <= '0;
            state   <= S_DONE;
          end else begin
            wallx     <= wx_c;
            wally     <= wy_c;
            ax        <= AW'(mag(wx_c - x));
            ay        <= AW'(mag(wy_c - y));
            adx       <= mag(dx);
            ady       <= mag(dy);
            dx_zero   <= dx == 0;
            dy_zero   <= dy == 0;
            dx_neg    <= dx[CW-1];
            dy_neg    <= dy[CW-1];
            state     <= S_MUL;
          end
        end
        S_MUL: begin
          if (mdone_x) state <= S_CMP;
        end
        S_CMP: begin
          if (dx_zero) begin
            stepx    <= 1'b0;
            dividend <= pyx;
            divisor  <= ady;
          end else if (dy_zero || pxy < pyx) begin
            stepx    <= 1'b1;
            dividend <= pxy;
            divisor  <= adx;
          end else begin
            stepx    <= 1'b0;
            dividend <= pyx;
            divisor  <= ady;
          end
          state     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) state <= S_UPD;
        end
        S_UPD: begin
          x  <= nx;
          y  <= ny;
          ix <= nix;
          iy <= niy;
          n  <= n + SNW'(1);
          if (is_wall) begin
            res_hit <= 1'b1;
            res_x   <= cx;
            res_y   <= cy;
            res_u   <= cu;
            state   <= S_DONE;
          end else if (at_end || n == SNW'(MAXS - 1)) begin
            res_hit <= 1'b0;
            res_x   <= '0;
            res_y   <= '0;
            res_u   <= '0;
            state   <= S_DONE;
          end else begin
            state <= S_SETUP;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            hit       <= res_hit;
            hit_x     <= res_x;
            hit_y     <= res_y;
            wall_u    <= res_u;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_mul_lockstep: assert property (@(posedge clk) disable iff (rst)
    mdone_x == mdone_y)
    else $error("multipliers out of step");

  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    div_done |-> quot <= AW'(ONE))
    else $error("crossing offset exceeds one cell");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD |-> n < SNW'(MAXS))
    else $error("step count overrun");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result beat without finished walk");
endmodule
